// ===== design/bdc_pkg.sv =====
// Package for the braille dot canvas: sizes, mode and register codes, payload types,
// the queue command type and the dot-order and clamp helpers.
// No dependencies.
package bdc_pkg;

  localparam int MAX_COLS   = 16;
  localparam int MAX_ROWS   = 16;
  localparam int CELLS      = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] MODE_SET    = 3'd0;
  localparam logic [2:0] MODE_CLR    = 3'd1;
  localparam logic [2:0] MODE_CLRALL = 3'd2;
  localparam logic [2:0] MODE_FILL   = 3'd3;
  localparam logic [2:0] MODE_RENDER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  localparam logic [15:0] CODE_BASE = 16'h2800;
  localparam logic [7:0]  UTF8_LEAD = 8'hE0;
  localparam logic [7:0]  UTF8_CONT = 8'h80;
  localparam logic [5:0]  CONT_MASK = 6'h3F;
  localparam logic [7:0]  NEWLINE   = 8'h0A;
  localparam logic [7:0]  ALL_DOTS  = 8'hFF;

  localparam logic [7:0] DOT_WEIGHT [8] = '{8'h01, 8'h02, 8'h04, 8'h40,
                                            8'h08, 8'h10, 8'h20, 8'h80};

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] x;
    logic [5:0] y;
    logic [3:0] row;
  } bdc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       status;
  } bdc_out_t;

  typedef enum logic [1:0] {
    K_PIXEL,
    K_FILL,
    K_RENDER,
    K_REJECT
  } bdc_kind_t;

  typedef struct packed {
    bdc_kind_t         kind;
    logic              val;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_idx;
    logic [ROW_W-1:0]  row;
  } bdc_cmd_t;

  function automatic logic [7:0] to_dots(input logic [7:0] mask);
    logic [7:0] d;
    d = '0;
    for (int j = 0; j < 8; j++) begin
      if (mask[j]) d = d | DOT_WEIGHT[j];
    end
    return d;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int top);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (int'(v) > top) r = CFG_W'(top);
    else r = v;
    return r;
  endfunction

endpackage

// ===== design/bdc_front.sv =====
// Front end: accepts input beats, range-checks them and turns them into queue commands.
// Depends on bdc_pkg.
module bdc_front (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bdc_pkg::bdc_in_t        in_data,
  input  logic [bdc_pkg::CFG_W-1:0] cols_i,
  input  logic [bdc_pkg::CFG_W-1:0] rows_i,
  input  logic                    q_full,
  input  logic                    clearing,
  output logic                    q_push,
  output bdc_pkg::bdc_cmd_t       q_cmd
);
  import bdc_pkg::*;

  logic [5:0] x_lim;
  logic [6:0] y_lim;
  logic       px_ok;
  logic       row_ok;

  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;

  assign x_lim  = {cols_i, 1'b0};
  assign y_lim  = {rows_i, 2'b00};
  assign px_ok  = ({1'b0, in_data.x} < x_lim) && ({1'b0, in_data.y} < y_lim);
  assign row_ok = {1'b0, in_data.row} < rows_i;

  always_comb begin
    q_cmd.kind    = K_REJECT;
    q_cmd.val     = 1'b0;
    q_cmd.addr    = ADDR_W'(32'(in_data.y[5:2]) * MAX_COLS + 32'(in_data.x[4:1]));
    q_cmd.bit_idx = {in_data.x[0], in_data.y[1:0]};
    q_cmd.row     = ROW_W'(in_data.row);
    unique case (in_data.mode) inside
      MODE_SET, MODE_CLR: begin
        q_cmd.kind = px_ok ? K_PIXEL : K_REJECT;
        q_cmd.val  = (in_data.mode == MODE_SET);
      end
      MODE_CLRALL, MODE_FILL: begin
        q_cmd.kind = K_FILL;
        q_cmd.val  = (in_data.mode == MODE_FILL);
      end
      MODE_RENDER: begin
        q_cmd.kind = row_ok ? K_RENDER : K_REJECT;
      end
      default: begin
        q_cmd.kind = K_REJECT;
      end
    endcase
  end

endmodule

// ===== design/bdc_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on bdc_pkg.
module bdc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bdc_pkg::bdc_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output bdc_pkg::bdc_cmd_t head,
  output logic              empty
);
  import bdc_pkg::*;

  bdc_cmd_t            slot_r [FIFO_DEPTH];
  logic [FPTR_W-1:0]   wr_ptr_r;
  logic [FPTR_W-1:0]   rd_ptr_r;
  logic [FCNT_W-1:0]   cnt_r;
  logic [FCNT_W-1:0]   cnt_nxt;

  assign full  = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + FCNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - FCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == FIFO_DEPTH - 1) ? '0 : wr_ptr_r + FPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == FIFO_DEPTH - 1) ? '0 : rd_ptr_r + FPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== design/bdc_back.sv =====
// Back end: cell memory, post-reset clearing sweep, pixel read-modify-write, fill sweep,
// row rendering to UTF-8 and the result register. Depends on bdc_pkg.
module bdc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bdc_pkg::CFG_W-1:0] cols_i,
  input  logic [bdc_pkg::CFG_W-1:0] rows_i,
  input  bdc_pkg::bdc_cmd_t         q_head,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      clearing,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bdc_pkg::bdc_out_t         out_data
);
  import bdc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PX_WR, S_FILL, S_DONE,
    S_RN_RD, S_RN_B0, S_RN_B1, S_RN_B2, S_RN_NL
  } state_t;

  state_t            state_r;
  bdc_cmd_t          cmd_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [COL_W-1:0]  c_r;
  logic [ROW_W-1:0]  r_r;
  logic              status_r;
  logic              out_valid_r;
  bdc_out_t          out_data_r;

  logic [7:0]        mem [CELLS];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [ADDR_W-1:0] cell_addr;
  logic [7:0]        bit_mask;
  logic [15:0]       code;
  logic              last_col;
  logic              last_row;
  logic              can_emit;
  logic              emit;

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_emit  = !out_valid_r || out_ready;

  assign cell_addr = ADDR_W'(32'(r_r) * MAX_COLS + 32'(c_r));
  assign bit_mask  = 8'(1) << cmd_r.bit_idx;
  assign code      = CODE_BASE + {8'h00, to_dots(mem_q)};
  assign last_col  = (CFG_W'(c_r) + CFG_W'(1)) == cols_i;
  assign last_row  = (CFG_W'(r_r) + CFG_W'(1)) == rows_i;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    q_pop     = 1'b0;
    emit      = 1'b0;
    unique case (state_r) inside
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
      end
      S_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && q_head.kind == K_PIXEL) begin
          mem_re    = 1'b1;
          mem_raddr = q_head.addr;
        end
      end
      S_PX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cmd_r.addr;
        mem_wdata = (mem_q & ~bit_mask) | (cmd_r.val ? bit_mask : 8'h00);
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr;
        mem_wdata = cmd_r.val ? ALL_DOTS : 8'h00;
      end
      S_RN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr;
      end
      S_DONE, S_RN_B0, S_RN_B1, S_RN_B2, S_RN_NL: begin
        emit = can_emit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          sweep_r <= sweep_r + ADDR_W'(1);
          if (sweep_r == ADDR_W'(CELLS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r    <= q_head;
            c_r      <= '0;
            r_r      <= (q_head.kind == K_RENDER) ? q_head.row : '0;
            status_r <= (q_head.kind == K_REJECT);
            unique case (q_head.kind)
              K_PIXEL:  state_r <= S_PX_WR;
              K_FILL:   state_r <= S_FILL;
              K_RENDER: state_r <= S_RN_RD;
              default:  state_r <= S_DONE;
            endcase
          end
        end
        S_PX_WR: state_r <= S_DONE;
        S_FILL: begin
          if (last_col) begin
            c_r <= '0;
            if (last_row) state_r <= S_DONE;
            else r_r <= r_r + ROW_W'(1);
          end else begin
            c_r <= c_r + COL_W'(1);
          end
        end
        S_DONE: begin
          if (can_emit) begin
            out_data_r  <= '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1, status: status_r};
            state_r     <= S_IDLE;
          end
        end
        S_RN_RD: state_r <= S_RN_B0;
        S_RN_B0: begin
          if (can_emit) begin
            out_data_r  <= '{out_byte: UTF8_LEAD | {4'h0, code[15:12]},
                             byte_valid: 1'b1, last: 1'b0, status: 1'b0};
            state_r     <= S_RN_B1;
          end
        end
        S_RN_B1: begin
          if (can_emit) begin
            out_data_r  <= '{out_byte: UTF8_CONT | {2'b00, code[11:6] & CONT_MASK},
                             byte_valid: 1'b1, last: 1'b0, status: 1'b0};
            state_r     <= S_RN_B2;
          end
        end
        S_RN_B2: begin
          if (can_emit) begin
            out_data_r  <= '{out_byte: UTF8_CONT | {2'b00, code[5:0] & CONT_MASK},
                             byte_valid: 1'b1, last: 1'b0, status: 1'b0};
            if (last_col) begin
              state_r <= S_RN_NL;
            end else begin
              c_r     <= c_r + COL_W'(1);
              state_r <= S_RN_RD;
            end
          end
        end
        S_RN_NL: begin
          if (can_emit) begin
            out_data_r  <= '{out_byte: NEWLINE, byte_valid: 1'b1, last: 1'b1, status: 1'b0};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/braille_dot_canvas.sv =====
// Braille dot canvas top level: configuration registers, front end, command queue, back end.
// Pixel ops read the cell and then write it back; clear/fill all writes every cell of the
// active area in turn. Render reads each cell of the row and emits its three UTF-8 bytes,
// then a newline, paced by the single cell memory read port and the one-beat result register.
// Reset (synchronous, rst_n low): registers to 16, then a memory clearing sweep
// with in_ready low. Depends on bdc_pkg, bdc_front, bdc_fifo, bdc_back.
module braille_dot_canvas (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bdc_pkg::bdc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bdc_pkg::bdc_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_W-1:0]     cfg_wdata
);
  import bdc_pkg::*;

  logic [CFG_W-1:0] cols_r;
  logic [CFG_W-1:0] rows_r;
  logic             q_push;
  bdc_cmd_t         q_cmd;
  logic             q_full;
  logic             q_pop;
  bdc_cmd_t         q_head;
  logic             q_empty;
  logic             clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= clamp_cfg(CFG_W'(16), MAX_COLS);
      rows_r <= clamp_cfg(CFG_W'(16), MAX_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cols_r <= clamp_cfg(cfg_wdata, MAX_COLS);
        CFG_ROWS: rows_r <= clamp_cfg(cfg_wdata, MAX_ROWS);
        default: begin
        end
      endcase
    end
  end

  bdc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cols_i   (cols_r),
    .rows_i   (rows_r),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  bdc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  bdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cols_i    (cols_r),
    .rows_i    (rows_r),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/bdc_checker.sv =====
// Port-level checker for braille_dot_canvas and the bind that attaches it.
// Depends on bdc_pkg and braille_dot_canvas.
module bdc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bdc_pkg::bdc_out_t out_data
);
  import bdc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_no_byte_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.last && out_data.out_byte == 8'h00)
    else $error("empty result beat not final or not zero");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && !out_data.byte_valid)
    else $error("rejected request produced a byte");

  a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid && out_data.last |-> out_data.out_byte == NEWLINE)
    else $error("render did not end with newline");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing sweep");

endmodule

bind braille_dot_canvas bdc_checker u_bdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/bdc_canvas_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the braille dot canvas: tracks the cell masks and the area registers,
// predicts every result beat and compares it with the result channel.
// Depends on bdc_pkg.
module bdc_canvas_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bdc_pkg::bdc_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bdc_pkg::bdc_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fault_count,
  output int                            beats_pending
);
  import bdc_pkg::*;

  localparam logic [15:0] GLYPH_BASE = 16'h2800;
  localparam logic [7:0]  LEAD_BYTE  = 8'hE0;
  localparam logic [7:0]  CONT_BYTE  = 8'h80;
  localparam logic [7:0]  LF_BYTE    = 8'h0A;
  localparam logic [7:0]  FULL_MASK  = 8'hFF;

  logic [7:0] cell_mask [CELLS];
  int         area_cols;
  int         area_rows;
  bdc_out_t   due_beats [$];

  function automatic int clip_area(input logic [CFG_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic bdc_out_t beat(input logic [7:0] b, input logic v, input logic l,
                                    input logic s);
    bdc_out_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.status     = s;
    return r;
  endfunction

  task automatic note_fault(input string msg);
    $display("%0t ns: %s", $time, msg);
    fault_count++;
  endtask

  task automatic apply_request(input bdc_in_t req);
    logic [7:0]  mask;
    logic [7:0]  dots;
    logic [15:0] code;
    int          slot;
    case (req.mode)
      MODE_SET, MODE_CLR: begin
        if (int'(req.x) >= 2 * area_cols || int'(req.y) >= 4 * area_rows) begin
          due_beats.push_back(beat('0, 1'b0, 1'b1, 1'b1));
        end else begin
          slot = int'(req.y[5:2]) * MAX_COLS + int'(req.x[4:1]);
          cell_mask[slot][{req.x[0], req.y[1:0]}] = (req.mode == MODE_SET);
          due_beats.push_back(beat('0, 1'b0, 1'b1, 1'b0));
        end
      end
      MODE_CLRALL, MODE_FILL: begin
        for (int r = 0; r < area_rows; r++) begin
          for (int c = 0; c < area_cols; c++) begin
            cell_mask[r * MAX_COLS + c] = (req.mode == MODE_FILL) ? FULL_MASK : '0;
          end
        end
        due_beats.push_back(beat('0, 1'b0, 1'b1, 1'b0));
      end
      MODE_RENDER: begin
        if (int'(req.row) >= area_rows) begin
          due_beats.push_back(beat('0, 1'b0, 1'b1, 1'b1));
        end else begin
          for (int c = 0; c < area_cols; c++) begin
            mask = cell_mask[int'(req.row) * MAX_COLS + c];
            dots = {mask[7], mask[3], mask[6:4], mask[2:0]};
            code = GLYPH_BASE + {8'h00, dots};
            due_beats.push_back(beat(LEAD_BYTE | {4'h0, code[15:12]}, 1'b1, 1'b0, 1'b0));
            due_beats.push_back(beat(CONT_BYTE | {2'b00, code[11:6]}, 1'b1, 1'b0, 1'b0));
            due_beats.push_back(beat(CONT_BYTE | {2'b00, code[5:0]}, 1'b1, 1'b0, 1'b0));
          end
          due_beats.push_back(beat(LF_BYTE, 1'b1, 1'b1, 1'b0));
        end
      end
      default: begin
        due_beats.push_back(beat('0, 1'b0, 1'b1, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    bdc_out_t due;
    if (!rst_n) begin
      foreach (cell_mask[i]) cell_mask[i] = '0;
      area_cols = MAX_COLS;
      area_rows = MAX_ROWS;
      due_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_beats.size() == 0) begin
          note_fault($sformatf("result beat %h arrived with none due", out_data));
        end else begin
          due = due_beats.pop_front();
          if (out_data.out_byte !== due.out_byte)
            note_fault($sformatf("out_byte %h, due %h", out_data.out_byte, due.out_byte));
          if (out_data.byte_valid !== due.byte_valid)
            note_fault($sformatf("byte_valid %b, due %b", out_data.byte_valid,
                                 due.byte_valid));
          if (out_data.last !== due.last)
            note_fault($sformatf("last %b, due %b", out_data.last, due.last));
          if (out_data.status !== due.status)
            note_fault($sformatf("status %b, due %b", out_data.status, due.status));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_COLS) area_cols = clip_area(cfg_wdata, MAX_COLS);
        else if (cfg_index == CFG_ROWS) area_rows = clip_area(cfg_wdata, MAX_ROWS);
      end
      if (in_valid && in_ready) apply_request(in_data);
    end
    beats_pending <= due_beats.size();
  end

endmodule

// ===== tb/sv/tb_braille_dot_canvas.sv =====
`timescale 1ns / 100ps
// Top of the braille dot canvas testbench: clock, reset, request and result-channel
// traffic, area register phases and the verdict.
// Depends on bdc_pkg, braille_dot_canvas and bdc_canvas_checker.
module tb_braille_dot_canvas;
  import bdc_pkg::*;

  localparam int               WATCHDOG_LIMIT = 4000;
  localparam int               LONG_HOLD      = 300;
  localparam int               PHASE_ITEMS    = 60;
  localparam int               RANDOM_PHASES  = 6;
  localparam int               TAIL_CYCLES    = 64;
  localparam logic [2:0]       MODE_SPARE_LO  = MODE_RENDER + 3'd1;
  localparam logic [2:0]       MODE_SPARE_HI  = '1;
  localparam logic [CFG_W-1:0] CFG_TOP        = '1;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  bdc_in_t              in_data     = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  bdc_out_t             out_data;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_wdata   = '0;
  int                   fault_count;
  int                   beats_pending;
  int                   idle_run    = 0;
  int                   area_cols   = MAX_COLS;
  int                   area_rows   = MAX_ROWS;
  bit                   hold_output = 1'b0;

  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  braille_dot_canvas uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bdc_canvas_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fault_count   (fault_count),
    .beats_pending (beats_pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run == WATCHDOG_LIMIT) begin
        $display("tb_braille_dot_canvas: errors");
        $finish;
      end
    end
  end

  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clip_area(input logic [CFG_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic logic [CFG_W-1:0] pick_area();
    if ($urandom_range(0, 9) < 7) return CFG_W'($urandom_range(1, 4));
    return CFG_W'($urandom_range(0, CFG_TOP));
  endfunction

  function automatic bdc_in_t make_req(input logic [2:0] mode, input logic [4:0] x,
                                       input logic [5:0] y, input logic [3:0] row);
    bdc_in_t req;
    req.mode = mode;
    req.x    = x;
    req.y    = y;
    req.row  = row;
    return req;
  endfunction

  function automatic bdc_in_t random_req();
    bdc_in_t req;
    int      pick;
    req  = make_req(3'($urandom), 5'($urandom), 6'($urandom), 4'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      req.mode = (pick < 45) ? MODE_SET : MODE_CLR;
      req.x    = 5'($urandom_range(0, 2 * area_cols - 1));
      req.y    = 6'($urandom_range(0, 4 * area_rows - 1));
    end else if (pick < 72) begin
      req.mode = MODE_RENDER;
      req.row  = 4'($urandom_range(0, area_rows - 1));
    end else if (pick < 76) begin
      req.mode = (pick < 74) ? MODE_FILL : MODE_CLRALL;
    end else if (pick < 88) begin
      req.mode = (pick < 82) ? MODE_SET : MODE_CLR;
    end else if (pick < 95) begin
      req.mode = MODE_RENDER;
    end else begin
      req.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    end
    return req;
  endfunction

  task automatic offer(input bdc_in_t req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic program_area(input logic [CFG_W-1:0] cols_code,
                              input logic [CFG_W-1:0] rows_code);
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_pending != 0);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_wdata <= cols_code;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= rows_code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    area_cols = clip_area(cols_code, MAX_COLS);
    area_rows = clip_area(rows_code, MAX_ROWS);
  endtask

  initial begin : receiver
    int gap;
    int slots;
    bit calm;
    slots = 0;
    calm  = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end
      if (slots % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : idle_cycles();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      slots++;
    end
  end

  initial begin : stimulus
    bit calm;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_ready);

    program_area(CFG_W'(MAX_COLS), CFG_W'(MAX_ROWS));
    offer(make_req(MODE_FILL, '0, '0, '0), 0);
    offer(make_req(MODE_RENDER, '0, '0, '0), 0);
    offer(make_req(MODE_RENDER, '0, '0, '1), 0);
    offer(make_req(MODE_CLRALL, '1, '1, '1), 0);
    // one mask bit per cell, so each dot position shows up on its own
    for (int b = 0; b < 8; b++) begin
      offer(make_req(MODE_SET, 5'(2 * b + b / 4), 6'(b % 4), 4'(b)), 0);
    end
    offer(make_req(MODE_RENDER, '1, '1, '0), 0);
    offer(make_req(MODE_SET, '1, '1, '0), 0);
    offer(make_req(MODE_CLR, '0, '0, '1), 0);
    offer(make_req(MODE_RENDER, '0, '0, '1), 0);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      offer(make_req(3'(m), '1, '1, '1), 0);
    end

    program_area('0, '0);
    offer(make_req(MODE_SET, 5'd2, '0, '0), 0);
    offer(make_req(MODE_SET, '0, 6'd4, '0), 0);
    offer(make_req(MODE_CLR, '1, '1, '0), 0);
    offer(make_req(MODE_RENDER, '0, '0, 4'd1), 0);
    offer(make_req(MODE_RENDER, '0, '0, '1), 0);
    offer(make_req(MODE_FILL, '0, '0, '0), 0);
    offer(make_req(MODE_CLR, 5'd1, 6'd3, '0), 0);
    offer(make_req(MODE_RENDER, '0, '0, '0), 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_area(5'd1, CFG_TOP);
        1: program_area(CFG_TOP, 5'd1);
        2: program_area(CFG_W'(MAX_COLS), CFG_W'(MAX_ROWS));
        default: program_area(pick_area(), pick_area());
      endcase
      // starve the result side so the request side backs up
      if (p == 2) hold_output = 1'b1;
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer(random_req(), calm ? 0 : idle_cycles());
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (beats_pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_braille_dot_canvas: clean");
    end else begin
      $display("tb_braille_dot_canvas: errors");
    end
    $finish;
  end

endmodule
